// ----- sv/base64_stream_encoder_top_defines.svh -----
// Assertion macros shared by the encoder modules.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef BASE64_STREAM_ENCODER_TOP_DEFINES_SVH
`define BASE64_STREAM_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B64E_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define B64E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/b64e_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, constants and the character table of the Base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Number of trailing '=' characters in a group
  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_ONE  = 2'd1;
  localparam logic [1:0] PAD_TWO  = 2'd2;

  localparam logic [6:0] PAD_CHAR = 7'h3D;

  // One complete group of three bytes, ready to be turned into four characters
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  pad;
    logic        last;
  } group_t;

  // Write side of the group queue
  typedef struct packed {
    logic   valid;
    group_t group;
  } push_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Map a 6-bit value to its ASCII character
  function automatic logic [6:0] b64_char(input logic [5:0] sextet);
    logic [6:0] s;
    logic [6:0] code;
    s = {1'b0, sextet};
    if (sextet < 6'd26) begin
      code = 7'h41 + s;
    end else if (sextet < 6'd52) begin
      code = 7'h61 + s - 7'd26;
    end else if (sextet < 6'd62) begin
      code = 7'h30 + s - 7'd52;
    end else if (sextet == 6'd62) begin
      code = 7'h2B;
    end else begin
      code = 7'h2F;
    end
    return code;
  endfunction

endpackage

// ----- sv/base64_stream_encoder_top.sv -----
`timescale 1ns / 1ps
// Path: a completed group is written into the queue, then loaded into the emitter's group
//   register, and each of its characters then passes through the output register.
// Throughput: one byte per cycle into a two-group queue while it is not full; the emitter
//   sends one character per cycle while out_stall is low, four for each group of three bytes.
// Reset: synchronous, active high; clears group position, queue and emitter state.
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming Base64 encoder with '=' padding and a last-character flag.
// ----------------------------------------------------------------------------
module base64_stream_encoder_top (
  input  logic       clk,
  input  logic       rst,
  // byte channel: transfer when in_valid is high and in_stall is low
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  // character channel: transfer when out_valid is high and out_stall is low
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] char_code,
  output logic       last_char
);

  b64e_pkg::push_t  push;
  b64e_pkg::qstat_t qstat;
  b64e_pkg::group_t head;
  logic             pop;

  // Front: gather bytes, emit a group on the third byte or on end of message
  b64e_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .qstat          (qstat),
    .push           (push)
  );

  // Queue: decouple byte intake from character output
  b64e_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // Back: map sextets to characters, pad, flag the final character
  b64e_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .qstat     (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last_char (last_char)
  );

endmodule

// ----- sv/b64e_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_front
// Gathers input bytes into groups of three and queues each finished group.
// ----------------------------------------------------------------------------
module b64e_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              end_of_message,
  input  b64e_pkg::qstat_t  qstat,
  output b64e_pkg::push_t   push
);

  logic [1:0] pos;
  logic [1:0] pos_next;
  logic [7:0] pend0;
  logic [7:0] pend1;
  logic       accept;

  // Hold off input while the queue has no room
  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos_next        = pos;
    push.valid      = 1'b0;
    push.group.word = {data_byte, 16'h0000};
    push.group.pad  = b64e_pkg::PAD_TWO;
    push.group.last = 1'b1;
    if (accept) begin
      case (pos)
        2'd1: begin
          if (end_of_message) begin
            push.valid      = 1'b1;
            push.group.word = {pend0, data_byte, 8'h00};
            push.group.pad  = b64e_pkg::PAD_ONE;
            pos_next        = 2'd0;
          end else begin
            pos_next = 2'd2;
          end
        end
        2'd2: begin
          push.valid      = 1'b1;
          push.group.word = {pend0, pend1, data_byte};
          push.group.pad  = b64e_pkg::PAD_NONE;
          push.group.last = end_of_message;
          pos_next        = 2'd0;
        end
        default: begin
          // start of a group; an unused position counts as the start too
          push.valid = end_of_message;
          pos_next   = end_of_message ? 2'd0 : 2'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 2'd0;
    end else begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos == 2'd1)) begin
      pend1 <= data_byte;
    end
    if (accept && (pos != 2'd1) && (pos != 2'd2)) begin
      pend0 <= data_byte;
    end
  end

endmodule

// ----- sv/b64e_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_queue
// Short queue of finished groups between the byte gatherer and the emitter.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_top_defines.svh"

module b64e_queue (
  input  logic                clk,
  input  logic                rst,
  input  b64e_pkg::push_t     push,
  input  logic                pop,
  output b64e_pkg::group_t    head,
  output b64e_pkg::qstat_t    qstat
);

  b64e_pkg::group_t               slots [b64e_pkg::QDEPTH];
  logic [b64e_pkg::QPTR_W-1:0]    wr_ptr;
  logic [b64e_pkg::QPTR_W-1:0]    rd_ptr;
  logic [b64e_pkg::QCNT_W-1:0]    count;
  logic                           do_push;
  logic                           do_pop;

  assign qstat.full  = (count == b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH));
  assign qstat.empty = (count == '0);
  assign do_push     = push.valid && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == b64e_pkg::QPTR_W'(b64e_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.group;
    end
  end

  `B64E_ASSERT_NOW(a_no_push_full, push.valid, !qstat.full, "group pushed into full queue")
  `B64E_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty, "group popped from empty queue")
  `B64E_ASSERT_NOW(a_count_range, 1'b1, count <= b64e_pkg::QCNT_W'(b64e_pkg::QDEPTH), "queue count beyond depth")

endmodule

// ----- sv/b64e_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64e_back
// Turns each queued group into four characters, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`include "base64_stream_encoder_top_defines.svh"

module b64e_back (
  input  logic               clk,
  input  logic               rst,
  input  b64e_pkg::group_t   head,
  input  b64e_pkg::qstat_t   qstat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         char_code,
  output logic               last_char
);

  b64e_pkg::group_t grp;
  logic             busy;
  logic [1:0]       idx;
  logic             out_ld;
  logic [5:0]       sextet;
  logic             padded;
  logic [6:0]       code;

  assign out_ld = !out_valid || !out_stall;
  // Take the next group when idle, or as the fourth character leaves
  assign pop    = !qstat.empty && (!busy || (out_ld && (idx == 2'd3)));

  always_comb begin
    case (idx)
      2'd0:    sextet = grp.word[23:18];
      2'd1:    sextet = grp.word[17:12];
      2'd2:    sextet = grp.word[11:6];
      default: sextet = grp.word[5:0];
    endcase
    padded = ({1'b0, idx} + {1'b0, grp.pad}) >= 3'd4;
    code   = padded ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(sextet);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_ld) begin
        out_valid <= busy;
      end
      if (busy && out_ld) begin
        idx <= idx + 2'd1;
        if (idx == 2'd3) begin
          busy <= pop;
        end
      end else if (pop) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      grp <= head;
    end
    if (busy && out_ld) begin
      char_code <= code;
      last_char <= grp.last && (idx == 2'd3);
    end
  end

  `B64E_ASSERT_NOW(a_idle_idx, !busy, idx == 2'd0, "character index moved while idle")
  `B64E_ASSERT_NEXT(a_hold_idx, busy && !out_ld, $stable(idx), "index advanced under stall")
  `B64E_ASSERT_NOW(a_pop_mid_group, busy && (idx != 2'd3), !pop, "group taken mid-group")

endmodule
